// ----- src/assert_macros.svh -----
// Assertion macros used by the timer table datapath.
// Expects clk and an active-low rst_n in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/ostt_pkg.sv -----
// Package for the one-shot timer table: widths, result kinds and the
// command/status structs between controller and datapath. No dependencies.
`default_nettype none
package ostt_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int DELAY_W    = 31;
  localparam int ID_W       = 16;
  localparam int KIND_W     = 2;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 16;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED   = 2'd0,
    KIND_FULL    = 2'd1,
    KIND_EXPIRED = 2'd2,
    KIND_IDLE    = 2'd3
  } kind_t;

  typedef struct packed {
    logic load;
    logic sched;
    logic tick;
    logic drain;
  } cmd_t;

  typedef struct packed {
    logic sched_done;
    logic tick_done;
    logic drain_done;
  } sts_t;

endpackage
`default_nettype wire

// ----- src/ostt_ctrl.sv -----
// Controller for the one-shot timer table: sequences schedule, tick scan
// and final result. Depends on ostt_pkg.
`default_nettype none
module ostt_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_op,
  output logic               in_ready,
  output ostt_pkg::cmd_t     cmd,
  input  wire ostt_pkg::sts_t sts
);
  import ostt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SCHED, S_TICK, S_DRAIN} state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd.load  = accept;
    cmd.sched = (state_r == S_SCHED);
    cmd.tick  = (state_r == S_TICK);
    cmd.drain = (state_r == S_DRAIN);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = in_op ? S_SCHED : S_TICK;
      end
      S_SCHED: begin
        if (sts.sched_done) state_nxt = S_IDLE;
      end
      S_TICK: begin
        if (sts.tick_done) state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        if (sts.drain_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/ostt_dp.sv -----
// Datapath for the one-shot timer table: live bits, slot memory, scan
// counter, pending expiry and output register. Depends on ostt_pkg.
`default_nettype none
`include "assert_macros.svh"
module ostt_dp #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire ostt_pkg::cmd_t              cmd,
  output ostt_pkg::sts_t                   sts,
  input  wire logic [ostt_pkg::DELAY_W-1:0] in_delay,
  input  wire logic [ostt_pkg::ID_W-1:0]    in_id,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ostt_pkg::kind_t                  out_kind,
  output logic [ostt_pkg::ID_W-1:0]        out_id,
  output logic                             out_last
);
  import ostt_pkg::*;

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MW = ID_W + 2 * DELAY_W;

  logic [MW-1:0]      mem [SLOTS];
  logic [MW-1:0]      rd_word_r;
  logic [SLOTS-1:0]   live_r, live_nxt;
  logic [IW-1:0]      idx_r, idx_nxt, rd_idx_r;
  logic               rd_vld_r, rd_vld_nxt, iss_done_r, iss_done_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [ID_W-1:0]    pend_id_r;
  logic [DELAY_W-1:0] delay_r;
  logic [ID_W-1:0]    id_r;
  logic               out_vld_r, out_vld_nxt;
  kind_t              out_kind_r;
  logic [ID_W-1:0]    out_id_r;
  logic               out_last_r;

  logic [DELAY_W-1:0] rd_count, rd_target;
  logic [ID_W-1:0]    rd_ident;
  logic               out_free, cur_free, at_end, sched_res;
  logic               ev_live, ev_exp, stall, adv, mem_re, mem_we, drain_push;
  logic [IW-1:0]      mem_wa;
  logic [MW-1:0]      mem_wd;
  logic               push, push_last;
  kind_t              push_kind;
  logic [ID_W-1:0]    push_id;

  assign rd_count  = rd_word_r[DELAY_W-1:0];
  assign rd_target = rd_word_r[2*DELAY_W-1:DELAY_W];
  assign rd_ident  = rd_word_r[MW-1:2*DELAY_W];

  assign out_free   = !out_vld_r || out_ready;
  assign cur_free   = !live_r[idx_r];
  assign at_end     = (idx_r == IW'(SLOTS - 1));
  assign sched_res  = cmd.sched && (cur_free || at_end) && out_free;

  assign ev_live    = rd_vld_r && live_r[rd_idx_r];
  assign ev_exp     = ev_live && !(rd_count < rd_target);
  assign stall      = ev_exp && pend_vld_r && !out_free;
  assign adv        = cmd.tick && !stall;
  assign mem_re     = adv && !iss_done_r;
  assign drain_push = cmd.drain && out_free;

  assign mem_we = (sched_res && cur_free) || (adv && ev_live && !ev_exp);
  assign mem_wa = cmd.sched ? idx_r : rd_idx_r;
  assign mem_wd = cmd.sched ? {id_r, delay_r, DELAY_W'(0)}
                            : {rd_ident, rd_target, rd_count + DELAY_W'(1)};

  always_comb begin
    push      = 1'b0;
    push_kind = KIND_IDLE;
    push_id   = '0;
    push_last = 1'b1;
    if (sched_res) begin
      push      = 1'b1;
      push_kind = cur_free ? KIND_SCHED : KIND_FULL;
    end else if (adv && ev_exp && pend_vld_r) begin
      push      = 1'b1;
      push_kind = KIND_EXPIRED;
      push_id   = pend_id_r;
      push_last = 1'b0;
    end else if (drain_push) begin
      push      = 1'b1;
      push_kind = pend_vld_r ? KIND_EXPIRED : KIND_IDLE;
      push_id   = pend_vld_r ? pend_id_r : '0;
    end
  end

  always_comb begin
    live_nxt     = live_r;
    idx_nxt      = idx_r;
    rd_vld_nxt   = rd_vld_r;
    iss_done_nxt = iss_done_r;
    pend_vld_nxt = pend_vld_r;
    out_vld_nxt  = out_vld_r;
    if (out_vld_r && out_ready) out_vld_nxt = 1'b0;
    if (push) out_vld_nxt = 1'b1;
    if (cmd.load) begin
      idx_nxt      = '0;
      rd_vld_nxt   = 1'b0;
      iss_done_nxt = 1'b0;
    end
    if (cmd.sched) begin
      if (sched_res && cur_free) live_nxt[idx_r] = 1'b1;
      if (!(cur_free || at_end)) idx_nxt = idx_r + IW'(1);
    end
    if (adv) begin
      rd_vld_nxt = mem_re;
      if (mem_re) begin
        if (at_end) iss_done_nxt = 1'b1;
        else idx_nxt = idx_r + IW'(1);
      end
      if (ev_exp) begin
        live_nxt[rd_idx_r] = 1'b0;
        pend_vld_nxt       = 1'b1;
      end
    end
    if (drain_push) pend_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r     <= '0;
      idx_r      <= '0;
      rd_vld_r   <= 1'b0;
      iss_done_r <= 1'b0;
      pend_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      live_r     <= live_nxt;
      idx_r      <= idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      iss_done_r <= iss_done_nxt;
      pend_vld_r <= pend_vld_nxt;
      out_vld_r  <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      delay_r <= in_delay;
      id_r    <= in_id;
    end
    if (mem_re) rd_idx_r <= idx_r;
    if (adv && ev_exp) pend_id_r <= rd_ident;
    if (push) begin
      out_kind_r <= push_kind;
      out_id_r   <= push_id;
      out_last_r <= push_last;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_word_r <= mem[idx_r];
  end

  always_comb begin
    sts.sched_done = sched_res;
    sts.tick_done  = cmd.tick && iss_done_r && !rd_vld_r;
    sts.drain_done = drain_push;
  end

  assign out_valid = out_vld_r;
  assign out_kind  = out_kind_r;
  assign out_id    = out_id_r;
  assign out_last  = out_last_r;

  `ASSERT_IMPL(a_push_free, push, out_free, "item pushed into occupied output register")
  `ASSERT_NEXT(a_exp_pend, adv && ev_exp, pend_vld_r, "expiry not held as pending")
  `ASSERT_IMPL(a_rw_apart, mem_we && mem_re, mem_wa != idx_r, "slot written and read together")

endmodule
`default_nettype wire

// ----- src/one_shot_timer_table_unit.sv -----
// Top level of the one-shot timer table: stream ports, controller and
// datapath. Depends on ostt_pkg, ostt_ctrl and ostt_dp.
//
//   port group  role     tdata / tuser / tlast
//   in_*        slave    tdata {timer_id, delay_ticks}, tuser op
//   out_*       master   tdata expired_id, tuser kind, tlast last
//
// Schedule: accept, then scan the slots up to the first free one.
// Tick: accept, a pass through the slot memory read pipeline, then the final
// item.
// Reset clears the live bits at once; the slot memory needs no clearing pass.
// A held output item stalls a schedule result and the final item, and with a
// second expiry pending freezes the tick scan.
`default_nettype none
module one_shot_timer_table_unit #(
  parameter int SLOTS = ostt_pkg::SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  input  wire logic [ostt_pkg::IN_DATA_W-1:0]  in_tdata,   // delay_ticks, timer_id, pad
  input  wire logic [0:0]                      in_tuser,   // op
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [ostt_pkg::OUT_DATA_W-1:0]      out_tdata,  // expired_id
  output logic [ostt_pkg::KIND_W-1:0]          out_tuser,  // kind
  output logic                                 out_tlast
);
  import ostt_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  kind_t kind;

  ostt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_op    (in_tuser[0]),
    .in_ready (in_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  ostt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_delay  (in_tdata[DELAY_W-1:0]),
    .in_id     (in_tdata[DELAY_W+ID_W-1:DELAY_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (kind),
    .out_id    (out_tdata),
    .out_last  (out_tlast)
  );

  assign out_tuser = kind;

endmodule
`default_nettype wire

// ----- sim/one_shot_timer_table_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking bench for one_shot_timer_table_unit: a scoreboard class tracks slot state
// and the results each accepted item should produce. Depends on ostt_pkg and the top level.
module one_shot_timer_table_unit_tb;
  import ostt_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam bit OP_TICK = 1'b0;
  localparam bit OP_SCHED = 1'b1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] id;
    logic        tl;
  } table_result_t;

  class timer_table_scoreboard;
    bit          live[SLOTS];
    bit [30:0]   count[SLOTS];
    bit [30:0]   target[SLOTS];
    bit [15:0]   ident[SLOTS];
    table_result_t pending_results[$];
    int mismatches = 0;
    int schedules = 0;
    int rejects = 0;
    int ticks = 0;
    int expiries = 0;
    int checked = 0;

    function void note_item(bit op, bit [30:0] delay, bit [15:0] id);
      int s;
      int total;
      int seen;
      bit placed;
      placed = 1'b0;
      if (op == OP_SCHED) begin
        for (s = 0; s < SLOTS && !placed; s++) begin
          if (!live[s]) begin
            live[s] = 1'b1;
            count[s] = '0;
            target[s] = delay;
            ident[s] = id;
            placed = 1'b1;
          end
        end
        if (placed) begin
          schedules++;
          pending_results.push_back('{KIND_SCHED, 16'h0, 1'b1});
        end else begin
          rejects++;
          pending_results.push_back('{KIND_FULL, 16'h0, 1'b1});
        end
      end else begin
        ticks++;
        total = 0;
        for (s = 0; s < SLOTS; s++)
          if (live[s] && count[s] >= target[s]) total++;
        seen = 0;
        for (s = 0; s < SLOTS; s++) begin
          if (live[s]) begin
            if (count[s] < target[s]) begin
              count[s] = count[s] + 31'd1;
            end else begin
              live[s] = 1'b0;
              seen++;
              pending_results.push_back('{KIND_EXPIRED, ident[s], seen == total});
            end
          end
        end
        expiries += total;
        if (total == 0) pending_results.push_back('{KIND_IDLE, 16'h0, 1'b1});
      end
    endfunction

    function void check_result(kind_t kind, logic [15:0] id, logic tl);
      table_result_t e;
      checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected item: kind=%0d id=%h last=%b", kind, id, tl);
      end else begin
        e = pending_results.pop_front();
        if (kind !== e.kind || id !== e.id || tl !== e.tl) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected kind=%0d id=%h last=%b, got kind=%0d id=%h last=%b",
                     e.kind, e.id, e.tl, kind, id, tl);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata = '0;
  logic [0:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  timer_table_scoreboard sb = new();
  int send_idle = 19;
  int recv_idle = 53;
  int hold_left = 0;
  int cycles = 0;
  int big_left = 2;

  one_shot_timer_table_unit #(.SLOTS(SLOTS)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),   // delay_ticks [30:0], timer_id [46:31], pad [47]
    .in_tuser  (in_tuser),   // op
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),  // expired_id
    .out_tuser (out_tuser),  // kind
    .out_tlast (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // hold off for long stretches on request, else stall at random
  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_idle);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready)
        sb.check_result(kind_t'(out_tuser), out_tdata, out_tlast);
    end
  end

  task automatic send_item(bit op, bit [30:0] delay, bit [15:0] id);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, id, delay};
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, delay, id);
  endtask

  task automatic run_random(int n_items);
    int done;
    int burst;
    int k;
    bit [30:0] delay;
    done = 0;
    while (done < n_items) begin
      burst = $urandom_range(1, 5);
      for (k = 0; k < burst && done < n_items; k++) begin
        if (big_left > 0 && $urandom_range(0, 99) == 0) begin
          big_left--;
          delay = 31'($urandom() | 32'h4000_0000);
        end else if ($urandom_range(0, 9) == 0) begin
          delay = 31'($urandom_range(0, 40));
        end else begin
          delay = 31'($urandom_range(0, 6));
        end
        send_item(OP_SCHED, delay, 16'($urandom_range(0, 16'hFFFF)));
        done++;
      end
      burst = $urandom_range(1, 4);
      for (k = 0; k < burst && done < n_items; k++) begin
        send_item(OP_TICK, 31'($urandom()), 16'($urandom()));
        done++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty tick, zero delay at the top id, a timer that never expires, ignored fields
    send_item(OP_TICK, 31'h0, 16'h0);
    send_item(OP_SCHED, 31'h0, 16'hFFFF);
    send_item(OP_SCHED, 31'h7FFF_FFFF, 16'h0);
    send_item(OP_TICK, 31'h7FFF_FFFF, 16'hFFFF);
    send_item(OP_TICK, 31'h0, 16'h0);
    // fill the table, overflow it, then tick until all delay-1 timers expire in one tick
    for (i = 0; i < SLOTS - 1; i++)
      send_item(OP_SCHED, 31'd1, 16'(16'h1000 + i));
    send_item(OP_SCHED, 31'd5, 16'hABCD);
    send_item(OP_TICK, 31'h0, 16'h0);
    send_item(OP_TICK, 31'h0, 16'h0);
    send_item(OP_TICK, 31'h0, 16'h0);

    run_random(157);
    send_idle = 53;
    recv_idle = 19;
    run_random(157);
    send_idle = 0;
    recv_idle = 0;
    hold_left = 400;
    for (i = 0; i < 40; i++)
      send_item(i % 3 == 0 ? OP_SCHED : OP_TICK, 31'($urandom_range(0, 2)),
                16'($urandom()));
    run_random(92);
    in_tvalid <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    sb.mismatches += sb.pending_results.size();

    $display("covered %0d schedules, %0d rejected as full, %0d ticks, %0d expiries",
             sb.schedules, sb.rejects, sb.ticks, sb.expiries);
    $display("checked %0d result items, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule
